@@ design/tmpd_pkg.sv @@
// Shared types and constants for the trimmed-mean power detector.
`default_nettype none
package tmpd_pkg;

	localparam int POWER_W     = 16;
	localparam int HOLD_W      = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = 2'd1;

	localparam logic KIND_POWER = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [CFG_DATA_W-1:0] HOLD_RESET = 32'd1000;

	typedef struct packed {
		logic store;   // write accepted power item into the ring
		logic tick;    // advance the hold count
		logic walk;    // read one ring entry
		logic trim;    // form trimmed sum magnitude and sign
		logic mul;     // multiply by reciprocal
		logic prod;    // take quotient estimate and its back product
		logic fix;     // correct quotient, restore sign
		logic emit;    // decide state and load the output register
	} tmpd_cmd_t;

	typedef struct packed {
		logic will_fill;  // ring is full once the current item is stored
		logic walk_last;  // last entry address is being issued
		logic out_free;   // output register can take a result
	} tmpd_sts_t;

endpackage
`default_nettype wire

@@ design/trimmed_mean_power_detector_core.sv @@
// Top level of the trimmed-mean power detector: controller, datapath, checks.
// Usage:
//   s_axis carries one item per handshake: tuser is the kind (power or tick),
//   tdata the frame power in signed Q8.8 dB. A tick advances the hold count.
//   A power item enters a ring of HISTORY_DEPTH entries; once the ring has
//   filled, each power item yields one item on m_axis with the trimmed mean
//   (sum less minimum and maximum, divided by HISTORY_DEPTH-2, toward zero),
//   the detect state and a state-changed flag. The cfg channel writes the
//   threshold (index 0) and hold ticks (index 1); other indexes are ignored.
//   The user writes only while the block is idle; it does not enforce this.
// Timing:
//   A tick or a power item before the ring is full leaves the block idle.
//   A power item with a full ring starts a computation, and no new item is
//   accepted until it ends: one ring entry per cycle through the single RAM
//   read port, then trim, reciprocal multiply, back product, correction and decision.
//   The result sits in an output register; if the receiver stalls, the next
//   item is still accepted and processed, and the block holds in its last
//   step until the output register frees.
// Reset: the ring is empty, detect state absent, hold count zero, threshold
//   zero and hold ticks 1000.
`default_nettype none
module trimmed_mean_power_detector_core
	import tmpd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] frame_power
	input  wire logic                   s_axis_tuser,   // [0] kind
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [15:0] average_power, [16] detect_state, [17] state_changed, [23:18] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	tmpd_cmd_t cmd;
	tmpd_sts_t sts;

	tmpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_kind (s_axis_tuser),
		.s_ready(s_axis_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	tmpd_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.frame_power(s_axis_tdata[POWER_W-1:0]),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

	// a result is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result loaded over a pending output item");

	// no ring walk while input is being accepted
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> !s_axis_tready)
		else $error("ring walk while idle");

	// a power item into a ring that is not yet full leaves the block idle
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_POWER) && !sts.will_fill)
		|=> s_axis_tready)
		else $error("result started before the ring filled");

	// ticks never start a computation
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_TICK))
		|=> (s_axis_tready && !cmd.walk))
		else $error("tick item started a computation");

endmodule
`default_nettype wire

@@ design/tmpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 5
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/tmpd_ctrl.sv @@
// Controller state machine: sequences ring walk, division and decision.
`default_nettype none
module tmpd_ctrl
	import tmpd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_valid,
	input  wire logic      s_kind,
	output logic           s_ready,
	input  wire tmpd_sts_t sts,
	output tmpd_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_TRIM   = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_PROD   = 3'd5;
	localparam logic [2:0] ST_FIX    = 3'd6;
	localparam logic [2:0] ST_DECIDE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_ready = (state_q == ST_IDLE);
	assign accept  = s_valid && s_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.store = accept && (s_kind == KIND_POWER);
				cmd.tick  = accept && (s_kind == KIND_TICK);
				if (cmd.store && sts.will_fill) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last read word lands in the accumulators here
			ST_DRAIN: state_d = ST_TRIM;
			ST_TRIM: begin
				cmd.trim = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold until the previous result has been taken
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ design/tmpd_dp.sv @@
// Datapath: history ring, min/max/sum walk, constant division, hold logic.
`default_nettype none
module tmpd_dp
	import tmpd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tmpd_cmd_t              cmd,
	output tmpd_sts_t                   sts,
	input  wire logic [POWER_W-1:0]     frame_power,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_TDATA_W-1:0]      out_data
);

	localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
	localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W   = POWER_W + $clog2(HISTORY_DEPTH) + 1;
	localparam int MAG_W   = SUM_W - 1;
	localparam int DIVISOR = HISTORY_DEPTH - 2;
	localparam int SHIFT   = SUM_W;
	localparam int RECIP_W = SHIFT + 1;
	localparam int RECIP   = (1 << SHIFT) / DIVISOR;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int PAD_W   = OUT_TDATA_W - POWER_W - 2;

	localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
	localparam logic [MAG_W-1:0]   DIV_C     = MAG_W'(DIVISOR);
	localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);
	localparam logic [FILL_W-1:0]  FULL_FILL = FILL_W'(HISTORY_DEPTH);
	localparam logic [HOLD_W-1:0]  TICK_MAX  = '1;

	logic signed [POWER_W-1:0] thr_q;
	logic        [HOLD_W-1:0]  hold_q;
	logic        [ADDR_W-1:0]  wr_slot_q;
	logic        [FILL_W-1:0]  fill_q;
	logic        [ADDR_W-1:0]  rd_idx_q;
	logic                      rd_vld_q;
	logic                      acc_first_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [POWER_W-1:0] min_q;
	logic signed [POWER_W-1:0] max_q;
	logic        [MAG_W-1:0]   mag_q;
	logic                      neg_q;
	logic        [PROD_W-1:0]  prod_q;
	logic        [MAG_W-1:0]   qest_q;
	logic        [MAG_W-1:0]   qd_q;
	logic signed [POWER_W-1:0] mean_q;
	logic                      present_q;
	logic        [HOLD_W-1:0]  ticks_q;
	logic                      out_valid_q;
	logic        [POWER_W-1:0] out_avg_q;
	logic                      out_state_q;
	logic                      out_changed_q;

	logic signed [POWER_W-1:0] rd_word;
	logic        [POWER_W-1:0] rd_raw;
	logic signed [SUM_W-1:0]   trim_sum;
	logic signed [SUM_W-1:0]   trim_abs;
	logic        [MAG_W-1:0]   qest;
	logic        [MAG_W-1:0]   rem;
	logic        [MAG_W-1:0]   q_fixed;
	logic        [POWER_W-1:0] q_short;
	logic                      above;
	logic                      present_d;

	tmpd_ram #(
		.WIDTH(POWER_W),
		.DEPTH(HISTORY_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.store),
		.wr_addr(wr_slot_q),
		.wr_data(frame_power),
		.rd_en  (cmd.walk),
		.rd_addr(rd_idx_q),
		.rd_data(rd_raw)
	);

	assign rd_word   = rd_raw;
	assign cfg_ready = 1'b1;

	assign sts.will_fill = (fill_q == FULL_FILL) || (fill_q == FULL_FILL - FILL_W'(1));
	assign sts.walk_last = (rd_idx_q == LAST_SLOT);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign trim_sum = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
	assign trim_abs = trim_sum[SUM_W-1] ? -trim_sum : trim_sum;
	assign qest     = prod_q[SHIFT +: MAG_W];
	assign rem      = mag_q - qd_q;
	assign q_fixed  = (rem >= DIV_C) ? qest_q + MAG_W'(1) : qest_q;
	assign q_short  = q_fixed[POWER_W-1:0];

	// detect decision on the finished mean
	assign above = (mean_q >= thr_q);
	always_comb begin
		present_d = present_q;
		if (above) begin
			present_d = 1'b1;
		end else if (present_q && (ticks_q > hold_q)) begin
			present_d = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_data[POWER_W-1:0];
				REG_HOLD:      hold_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ring pointers, walk control, detect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q   <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			acc_first_q <= 1'b0;
			present_q   <= 1'b0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.walk;
			if (cmd.store) begin
				wr_slot_q   <= (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + ADDR_W'(1);
				rd_idx_q    <= '0;
				acc_first_q <= 1'b1;
				if (fill_q != FULL_FILL) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.walk) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
			if (rd_vld_q) begin
				acc_first_q <= 1'b0;
			end
			if (cmd.tick && (ticks_q != TICK_MAX)) begin
				ticks_q <= ticks_q + HOLD_W'(1);
			end
			if (cmd.emit) begin
				present_q <= present_d;
				if (above) begin
					ticks_q <= '0;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accumulate and divide
	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			if (acc_first_q) begin
				sum_q <= SUM_W'(rd_word);
				min_q <= rd_word;
				max_q <= rd_word;
			end else begin
				sum_q <= sum_q + SUM_W'(rd_word);
				if (rd_word < min_q) begin
					min_q <= rd_word;
				end
				if (rd_word > max_q) begin
					max_q <= rd_word;
				end
			end
		end
		if (cmd.trim) begin
			neg_q <= trim_sum[SUM_W-1];
			mag_q <= trim_abs[MAG_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP_C);
		end
		// estimate is exact or one short
		if (cmd.prod) begin
			qest_q <= qest;
			qd_q   <= MAG_W'(qest * DIV_C);
		end
		if (cmd.fix) begin
			mean_q <= neg_q ? -q_short : q_short;
		end
		if (cmd.emit) begin
			out_avg_q     <= mean_q;
			out_state_q   <= present_d;
			out_changed_q <= (present_d != present_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{PAD_W{1'b0}}, out_changed_q, out_state_q, out_avg_q};

endmodule
`default_nettype wire
